FILE: rtl/core/alr_pkg.sv
// Package for the associated Legendre block: payload types, states, constants.
`default_nettype none
package alr_pkg;

  localparam int LMAX          = 8;
  localparam int OUT_FRAC_BITS = 24;
  localparam int IFB           = 30;

  localparam int KW   = 6;   // width of the small integer factors
  localparam int CNTW = 5;   // width of the degree counter
  localparam int MAGW = 62;  // working magnitude, up to 2^61

  localparam logic [MAGW-1:0] WORK_BOUND  = MAGW'(64'd1 << 61);
  localparam logic [MAGW-1:0] ONE_Q30     = MAGW'(64'd1 << IFB);
  localparam logic [47:0]     OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0]     OUT_NEG_MAG = 48'h8000_0000_0000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  typedef struct packed {
    logic [3:0]         degree;
    logic [3:0]         order;
    logic signed [31:0] arg;
  } item_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_RT,
    S_PMM_F0,
    S_PMM_F1,
    S_PMM_I,
    S_P1_F0,
    S_P1_F1,
    S_P1_I,
    S_RC_F0,
    S_RC_F1,
    S_RC_A,
    S_RC_B,
    S_DIV,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/assoc_legendre_recurrence.sv
// Associated Legendre function P_l^m(x) by sqrt and upward recurrence, iterative.
`default_nettype none
// One item at a time. An accepted item (degree l, order m, Q1.30 argument) yields one
// result: P_l^m(x) with the Condon-Shortley sign, 24 fraction bits, plus a status
// (ok, invalid request, saturated). The steps are a bit-serial square root when m > 0,
// the order steps, the first degree step, each further degree step through the
// restoring divider, and the load of the output register. An invalid request
// (m > l or l > 8) goes straight to the output load. The load waits while the previous
// result is still held. The next item is taken once the result is loaded into the
// output register.
module assoc_legendre_recurrence (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire alr_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output alr_pkg::result_t      result
);
  import alr_pkg::*;

  localparam int SH   = OUT_FRAC_BITS - IFB;
  localparam int SH_L = (SH > 0) ? SH : 0;
  localparam int SH_R = (SH < 0) ? -SH : 1;

  state_t state, state_next;

  logic [3:0]      deg, ord;
  logic [30:0]     x_mag;
  logic            x_neg;
  logic [30:0]     s;
  logic [MAGW-1:0] prev_mag, cur_mag, acc_mag;
  logic            prev_neg, cur_neg, acc_neg;
  logic [62:0]     lo;
  logic [CNTW-1:0] k;
  logic            ov_hit, ov_neg, invalid;
  logic [63:0]     sq_n, sq_r, sq_bit;
  logic [63:0]     dq;
  logic [4:0]      rem, dv;
  logic [5:0]      div_cnt;
  logic            d_neg;

  // input decode
  logic        req_bad;
  logic [31:0] x_clamp;
  assign req_bad = (item.order > item.degree) || (32'(item.degree) > 32'(LMAX));
  always_comb begin
    if (item.arg > 32'sd1073741824)       x_clamp = 32'sd1073741824;
    else if (item.arg < -32'sd1073741824) x_clamp = -32'sd1073741824;
    else                                  x_clamp = item.arg;
  end

  assign item_ready = (state == S_IDLE);

  // shared multiplier
  logic [31:0]     mul_a;
  logic [30:0]     mul_f;
  logic [62:0]     prod;
  logic [MAGW-1:0] op_mag;
  logic            op_neg, f_neg;
  always_comb begin
    op_mag = prev_mag;
    op_neg = prev_neg;
    mul_f  = x_mag;
    f_neg  = x_neg;
    if (state == S_PMM_F0 || state == S_PMM_F1) begin
      mul_f = s;
      f_neg = 1'b0;
    end
    if (state == S_RC_F0 || state == S_RC_F1) begin
      op_mag = cur_mag;
      op_neg = cur_neg;
    end
    unique case (state)
      S_SQ:                        mul_a = {1'b0, x_mag};
      S_PMM_F1, S_P1_F1, S_RC_F1:  mul_a = {2'b00, op_mag[MAGW-1:32]};
      default:                     mul_a = op_mag[31:0];
    endcase
  end
  assign prod = 63'(mul_a * mul_f);

  logic [63:0]     lo_rnd;
  logic [MAGW-1:0] frac_mag;
  assign lo_rnd   = {1'b0, lo} + (64'd1 << (IFB - 1));
  assign frac_mag = MAGW'({prod, 2'b00} + 65'(lo_rnd >> IFB));

  // small integer multiply with saturation at the working bound
  logic [MAGW-1:0]      mi_in, mi_res;
  logic                 mi_neg, mi_ovf;
  logic [KW-1:0]        mi_k;
  logic [MAGW+KW-1:0]   mi_prod;
  always_comb begin
    mi_in  = acc_mag;
    mi_neg = acc_neg;
    unique case (state)
      S_P1_I:  mi_k = KW'({ord, 1'b1});
      S_RC_B: begin
        mi_in  = prev_mag;
        mi_neg = prev_neg;
        mi_k   = KW'(k) + KW'(ord) - KW'(1);
      end
      default: mi_k = KW'({k, 1'b0}) - KW'(1);
    endcase
  end
  assign mi_prod = mi_in * mi_k;
  assign mi_ovf  = mi_prod > (MAGW+KW)'(WORK_BOUND);
  assign mi_res  = mi_ovf ? WORK_BOUND : mi_prod[MAGW-1:0];

  // difference a - b and its magnitude for the dividend
  logic signed [63:0] a_s, b_s, diff;
  logic [63:0]        ud;
  assign a_s  = acc_neg ? -$signed({2'b00, acc_mag}) : $signed({2'b00, acc_mag});
  assign b_s  = mi_neg ? -$signed({2'b00, mi_res}) : $signed({2'b00, mi_res});
  assign diff = a_s - b_s;
  assign ud   = diff[63] ? 64'(-diff) : 64'(diff);

  // square root step
  logic [63:0] sq_t;
  logic        sq_ge;
  assign sq_t  = sq_r + sq_bit;
  assign sq_ge = sq_n >= sq_t;

  // divider step
  logic [5:0]  rem_sh;
  logic        q_bit;
  assign rem_sh = {rem, dq[63]};
  assign q_bit  = rem_sh >= {1'b0, dv};
  logic [63:0] dq_next;
  assign dq_next = {dq[62:0], q_bit};

  // output conversion
  logic [47:0]   lim, out_mag;
  logic          out_neg, out_sat;
  logic [MAGW:0] rnd;
  always_comb begin
    out_neg = ov_hit ? ov_neg : cur_neg;
    lim     = out_neg ? OUT_NEG_MAG : OUT_POS_MAX;
    rnd     = {1'b0, cur_mag} + ((MAGW+1)'(1) << (SH_R - 1));
    out_sat = 1'b1;
    out_mag = lim;
    if (!ov_hit) begin
      if (SH >= 0) begin
        if ({2'b00, cur_mag} <= 64'(lim >> SH_L)) begin
          out_sat = 1'b0;
          out_mag = 48'({2'b00, cur_mag} << SH_L);
        end
      end else begin
        if (64'(rnd >> SH_R) <= 64'(lim)) begin
          out_sat = 1'b0;
          out_mag = 48'(rnd >> SH_R);
        end
      end
    end
  end

  logic out_free;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (req_bad)               state_next = S_FIN;
          else if (item.order != 0)  state_next = S_SQ;
          else if (item.degree != 0) state_next = S_P1_F0;
          else                       state_next = S_FIN;
        end
      end
      S_SQ:     state_next = S_RT;
      S_RT:     if (sq_bit[0]) state_next = S_PMM_F0;
      S_PMM_F0: state_next = S_PMM_F1;
      S_PMM_F1: state_next = S_PMM_I;
      S_PMM_I: begin
        if (k != CNTW'(ord))  state_next = S_PMM_F0;
        else if (deg > ord)   state_next = S_P1_F0;
        else                  state_next = S_FIN;
      end
      S_P1_F0:  state_next = S_P1_F1;
      S_P1_F1:  state_next = S_P1_I;
      S_P1_I:   state_next = (CNTW'(ord) + CNTW'(2) > CNTW'(deg)) ? S_FIN : S_RC_F0;
      S_RC_F0:  state_next = S_RC_F1;
      S_RC_F1:  state_next = S_RC_A;
      S_RC_A:   state_next = S_RC_B;
      S_RC_B:   state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == 6'd63) state_next = (k + CNTW'(1) > CNTW'(deg)) ? S_FIN : S_RC_F0;
      end
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      ov_hit       <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_FIN) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            deg      <= item.degree;
            ord      <= item.order;
            invalid  <= req_bad;
            x_neg    <= x_clamp[31];
            x_mag    <= x_clamp[31] ? 31'(-x_clamp) : x_clamp[30:0];
            prev_mag <= ONE_Q30;
            prev_neg <= 1'b0;
            cur_mag  <= ONE_Q30;
            cur_neg  <= 1'b0;
            k        <= CNTW'(1);
            ov_hit   <= 1'b0;
          end
        end
        S_SQ: begin
          sq_n   <= (64'd1 << 60) - {1'b0, prod};
          sq_r   <= '0;
          sq_bit <= 64'd1 << 62;
        end
        S_RT: begin
          if (sq_ge) begin
            sq_n <= sq_n - sq_t;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) s <= sq_ge ? 31'((sq_r >> 1) + sq_bit) : 31'(sq_r >> 1);
        end
        S_PMM_F0, S_P1_F0, S_RC_F0: lo <= prod;
        S_PMM_F1, S_P1_F1, S_RC_F1: begin
          acc_mag <= frac_mag;
          acc_neg <= op_neg ^ f_neg;
        end
        S_PMM_I, S_P1_I, S_RC_A, S_RC_B: begin
          if (mi_ovf && !ov_hit) begin
            ov_hit <= 1'b1;
            ov_neg <= mi_neg;
          end
          if (state == S_PMM_I) begin
            prev_mag <= mi_res;
            prev_neg <= ~mi_neg;
            cur_mag  <= mi_res;
            cur_neg  <= ~mi_neg;
            if (k != CNTW'(ord)) k <= k + CNTW'(1);
          end
          if (state == S_P1_I) begin
            cur_mag <= mi_res;
            cur_neg <= mi_neg;
            k       <= CNTW'(ord) + CNTW'(2);
          end
          if (state == S_RC_A) begin
            acc_mag <= mi_res;
            acc_neg <= mi_neg;
          end
          if (state == S_RC_B) begin
            dv      <= 5'(k - CNTW'(ord));
            dq      <= ud + 64'(5'(k - CNTW'(ord)) >> 1);
            d_neg   <= diff[63];
            rem     <= '0;
            div_cnt <= '0;
          end
        end
        S_DIV: begin
          rem     <= q_bit ? 5'(rem_sh - {1'b0, dv}) : rem_sh[4:0];
          dq      <= dq_next;
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd63) begin
            prev_mag <= cur_mag;
            prev_neg <= cur_neg;
            cur_mag  <= dq_next[MAGW-1:0];
            cur_neg  <= d_neg;
            k        <= k + CNTW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (invalid) begin
              result.value  <= '0;
              result.status <= ST_INVALID;
            end else begin
              result.value  <= out_neg ? -$signed(out_mag) : $signed(out_mag);
              result.status <= out_sat ? ST_SAT : ST_OK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_INVALID |-> result.value == '0)
    else $error("invalid request with nonzero value");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_SAT |->
      result.value == $signed(OUT_POS_MAX) || result.value == $signed(OUT_NEG_MAG))
    else $error("saturated result not at a limit");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dv >= 5'd2)
    else $error("recurrence divisor below two");

endmodule
`default_nettype wire

FILE: dv/assoc_legendre_recurrence_tb.sv
// Testbench for assoc_legendre_recurrence: directed table plus random items against a predictor.
`timescale 1ns / 1ps
module assoc_legendre_recurrence_tb;
  import alr_pkg::*;

  typedef struct {
    logic [3:0]  degree;
    logic [3:0]  order;
    logic [31:0] arg;
    bit          has_fixed;
    logic [47:0] value;
    logic [1:0]  status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;

  result_t expected_q[$];
  int mismatches = 0;
  bit stim_done = 1'b0;

  assoc_legendre_recurrence dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // a * f with f in Q1.30, round half away from zero
  function automatic longint frac_mul(longint a, longint f);
    logic [63:0] ua, uf, r;
    bit neg;
    ua = (a < 0) ? -a : a;
    uf = (f < 0) ? -f : f;
    neg = (a < 0) != (f < 0);
    r = (((ua >> 32) * uf) << 2) + ((((ua & 64'hFFFF_FFFF) * uf) + (64'd1 << 29)) >> 30);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint int_mul(longint v, logic [63:0] k, inout bit hit,
                                     inout bit hneg);
    logic [63:0] u, bound;
    bit neg;
    bound = 64'd1 << 61;
    neg = v < 0;
    u = neg ? -v : v;
    if (k != 0 && u > bound / k) begin
      if (!hit) begin
        hit = 1;
        hneg = neg;
      end
      u = bound;
    end else begin
      u = u * k;
    end
    return neg ? -longint'(u) : longint'(u);
  endfunction

  function automatic result_t legendre(logic [3:0] l, logic [3:0] m, logic signed [31:0] a);
    result_t r;
    longint x, s, prv, cur, nxt, pa, pb, d, rv;
    logic [63:0] ux, u, ud, lim;
    bit hit, hneg, neg;
    int k;
    hit = 0;
    hneg = 0;
    if (m > l || l > LMAX) begin
      r.value = '0;
      r.status = ST_INVALID;
      return r;
    end
    x = a;
    if (x > (64'sd1 <<< 30)) x = 64'sd1 <<< 30;
    if (x < -(64'sd1 <<< 30)) x = -(64'sd1 <<< 30);
    prv = 64'sd1 <<< 30;
    if (m > 0) begin
      ux = (x < 0) ? -x : x;
      s = isqrt((64'd1 << 60) - ux * ux);
      for (k = 1; k <= m; k++) prv = -int_mul(frac_mul(prv, s), 2 * k - 1, hit, hneg);
    end
    rv = prv;
    if (l > m) begin
      cur = int_mul(frac_mul(prv, x), 2 * m + 1, hit, hneg);
      for (k = m + 2; k <= l; k++) begin
        pa = int_mul(frac_mul(cur, x), 2 * k - 1, hit, hneg);
        pb = int_mul(prv, k + m - 1, hit, hneg);
        d = k - m;
        neg = (pa - pb) < 0;
        ud = neg ? -(pa - pb) : (pa - pb);
        ud = (ud + d / 2) / d;
        nxt = neg ? -longint'(ud) : longint'(ud);
        prv = cur;
        cur = nxt;
      end
      rv = cur;
    end
    r.status = ST_OK;
    if (hit) begin
      neg = hneg;
      u = neg ? 64'(OUT_NEG_MAG) : 64'(OUT_POS_MAX);
      r.status = ST_SAT;
    end else begin
      neg = rv < 0;
      u = neg ? -rv : rv;
      lim = neg ? 64'(OUT_NEG_MAG) : 64'(OUT_POS_MAX);
      u = (u + (64'd1 << (IFB - OUT_FRAC_BITS - 1))) >> (IFB - OUT_FRAC_BITS);
      if (u > lim) begin
        u = lim;
        r.status = ST_SAT;
      end
    end
    r.value = neg ? -u[47:0] : u[47:0];
    return r;
  endfunction

  // valid stays up after a transfer until the next call drops it or drives a new item
  task automatic send_item(logic [3:0] l, logic [3:0] m, logic [31:0] a, bit has_fixed,
                           logic [47:0] fv, logic [1:0] fs);
    result_t e;
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    e = legendre(l, m, a);
    if (has_fixed && (e.value !== fv || e.status !== fs))
      $display("predictor disagrees with table row l=%0d m=%0d", l, m);
    if (has_fixed) begin
      e.value = fv;
      e.status = fs;
    end
    item_valid <= 1'b1;
    item <= '{degree: l, order: m, arg: a};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_q.push_back(e);
  endtask

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(0, 5))
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return $urandom;
      3: return $urandom_range(0, 32'h4000_0000);
      default: return -$signed(32'($urandom_range(0, 32'h4000_0000)));
    endcase
  endfunction

  stim_row_t table_rows[] = '{
    '{4'd0, 4'd0, 32'h0000_0000, 1, 48'h00_0001_000000, ST_OK},
    '{4'd0, 4'd0, 32'h4000_0000, 1, 48'h00_0001_000000, ST_OK},
    '{4'd1, 4'd0, 32'h4000_0000, 1, 48'h00_0001_000000, ST_OK},
    '{4'd1, 4'd0, 32'hC000_0000, 1, 48'hFF_FFFF_000000, ST_OK},
    '{4'd1, 4'd1, 32'h0000_0000, 1, 48'hFF_FFFF_000000, ST_OK},
    '{4'd1, 4'd2, 32'h1234_5678, 1, 48'h0, ST_INVALID},
    '{4'd0, 4'd8, 32'h0000_0000, 1, 48'h0, ST_INVALID},
    '{4'd9, 4'd0, 32'h0000_0000, 1, 48'h0, ST_INVALID},
    '{4'd15, 4'd15, 32'hFFFF_FFFF, 1, 48'h0, ST_INVALID},
    '{4'd3, 4'd15, 32'h8000_0000, 1, 48'h0, ST_INVALID},
    '{4'd8, 4'd8, 32'h0000_0000, 0, 48'h0, ST_OK},
    '{4'd8, 4'd8, 32'h2000_0000, 0, 48'h0, ST_OK},
    '{4'd8, 4'd0, 32'h4000_0000, 0, 48'h0, ST_OK},
    '{4'd8, 4'd0, 32'hC000_0000, 0, 48'h0, ST_OK},
    '{4'd8, 4'd4, 32'h3000_0000, 0, 48'h0, ST_OK},
    '{4'd8, 4'd7, 32'h7FFF_FFFF, 0, 48'h0, ST_OK},
    '{4'd8, 4'd3, 32'h8000_0000, 0, 48'h0, ST_OK},
    '{4'd5, 4'd2, 32'h5555_5555, 0, 48'h0, ST_OK},
    '{4'd2, 4'd0, 32'h0000_0001, 0, 48'h0, ST_OK},
    '{4'd7, 4'd6, 32'hE000_0000, 0, 48'h0, ST_OK}
  };

  initial begin
    int n;
    logic [3:0] l, m;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i])
      send_item(table_rows[i].degree, table_rows[i].order, table_rows[i].arg,
                table_rows[i].has_fixed, table_rows[i].value, table_rows[i].status);
    for (n = 0; n < 1200; n++) begin
      if (n == 600) begin
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        l = 4'($urandom);
        m = 4'($urandom);
      end else begin
        l = 4'($urandom_range(0, LMAX));
        m = 4'($urandom_range(0, l));
      end
      send_item(l, m, rand_arg(), 0, '0, ST_OK);
    end
    item_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side: random stalls, with some results taken without a stall
  initial begin
    int stall;
    bit calm;
    forever begin
      @(posedge clk);
      calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 9);
      repeat (stall) @(posedge clk);
      result_ready <= 1'b1;
      @(posedge clk);
      while (!(result_valid && result_ready)) @(posedge clk);
      result_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: value=%h status=%0d",
                                       result.value, result.status);
      end else begin
        e = expected_q.pop_front();
        if (result.value !== e.value || result.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     e.value, e.status, result.value, result.status);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
